>>> sv/itc_pkg.sv
// ----------------------------------------------------------------------------
// itc_pkg
// Commands, register indexes, clock limits and shared types for the
// inactivity timeout and wall clock unit.
// ----------------------------------------------------------------------------
package itc_pkg;

  // command codes carried in the cmd field
  localparam logic [2:0] CMD_TICK     = 3'd0;
  localparam logic [2:0] CMD_ACTIVITY = 3'd1;
  localparam logic [2:0] CMD_SET_TIME = 3'd2;
  localparam logic [2:0] CMD_UNLOCK   = 3'd3;
  localparam logic [2:0] CMD_LOCK     = 3'd4;

  // configuration register indexes (byte address = 4 * index)
  localparam logic [2:0] REG_WARN    = 3'd0;
  localparam logic [2:0] REG_TIMEOUT = 3'd1;
  localparam logic [2:0] REG_PERIOD  = 3'd2;
  localparam logic [2:0] REG_OPEN    = 3'd3;
  localparam logic [2:0] REG_CLOSE   = 3'd4;

  // reset values of the configuration registers
  localparam logic [5:0] WARN_RESET    = 6'd18;
  localparam logic [5:0] TIMEOUT_RESET = 6'd30;
  localparam logic [5:0] PERIOD_RESET  = 6'd30;
  localparam logic [4:0] OPEN_RESET    = 5'd8;
  localparam logic [4:0] CLOSE_RESET   = 5'd20;

  // clock limits and counter saturation
  localparam logic [5:0] SECONDS_PER_MINUTE = 6'd60;
  localparam logic [5:0] MINUTES_PER_HOUR   = 6'd60;
  localparam logic [4:0] HOURS_PER_DAY      = 5'd24;
  localparam logic [5:0] COUNT_MAX          = 6'd63;

  typedef struct packed {
    logic [7:0] day;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
  } itc_time_t;

  typedef struct packed {
    logic [5:0] warn;
    logic [5:0] timeout;
    logic [5:0] period;
    logic [4:0] open;
    logic [4:0] close;
  } itc_cfg_t;

endpackage

>>> sv/inactivity_timeout_and_clock_unit.sv
// ----------------------------------------------------------------------------
// inactivity_timeout_and_clock_unit
// One-second tick block: idle timeout with warning blink, status heartbeat
// and a day/hour/minute/second wall clock with a service-hours flag.
// ----------------------------------------------------------------------------
// Each accepted word produces exactly one result word. All state updates for
// a word are computed in a single pass of short counter and compare logic
// from the state registers and written at the accept edge, together with the
// output register, so a new word can be taken every cycle that in_stall is
// low. in_stall rises only while a result in the output register is stalled
// downstream; pready is always high. The user must write configuration
// registers via the APB port only while no word is in flight (not enforced).
module inactivity_timeout_and_clock_unit
  import itc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,

  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,

  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  cmd,
  input  logic [7:0]  set_day,
  input  logic [4:0]  set_hour,
  input  logic [5:0]  set_minute,

  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic        blink_on,
  output logic        session_timeout,
  output logic        heartbeat,
  output logic        out_of_hours,
  output logic [7:0]  cur_day,
  output logic [4:0]  cur_hour,
  output logic [5:0]  cur_minute,
  output logic [5:0]  cur_second
);

  itc_cfg_t   cfg;
  logic [2:0] reg_index;
  logic       cfg_write;

  logic [5:0] idle_count, idle_count_next;
  logic       blinking, blinking_next;
  logic [5:0] beat_count, beat_count_next;
  logic       unlocked, unlocked_next;
  logic       clock_valid, clock_valid_next;
  logic       closed_flag, closed_flag_next;
  itc_time_t  clock_time, clock_time_next;
  logic       ended, beat;

  logic       in_accept;

  // intermediate tick values
  logic [5:0] idle_step;
  logic [5:0] beat_step;
  logic [5:0] sec_step;
  logic [5:0] min_step;
  logic [4:0] hour_step;
  itc_time_t  tick_time;

  assign pready    = 1'b1;
  assign reg_index = paddr[4:2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_comb begin
    case (reg_index)
      REG_WARN:    prdata = {26'd0, cfg.warn};
      REG_TIMEOUT: prdata = {26'd0, cfg.timeout};
      REG_PERIOD:  prdata = {26'd0, cfg.period};
      REG_OPEN:    prdata = {27'd0, cfg.open};
      REG_CLOSE:   prdata = {27'd0, cfg.close};
      default:     prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.warn    <= WARN_RESET;
      cfg.timeout <= TIMEOUT_RESET;
      cfg.period  <= PERIOD_RESET;
      cfg.open    <= OPEN_RESET;
      cfg.close   <= CLOSE_RESET;
    end else if (cfg_write) begin
      case (reg_index)
        REG_WARN:    cfg.warn    <= pwdata[5:0];
        REG_TIMEOUT: cfg.timeout <= pwdata[5:0];
        REG_PERIOD:  cfg.period  <= pwdata[5:0];
        REG_OPEN:    cfg.open    <= pwdata[4:0];
        REG_CLOSE:   cfg.close   <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  // hold new words only while a result waits on a stalled output
  assign in_stall  = out_valid && out_stall;
  assign in_accept = in_valid && !in_stall;

  // clock advance with carries
  always_comb begin
    tick_time = clock_time;
    sec_step  = clock_time.second + 6'd1;
    min_step  = clock_time.minute + 6'd1;
    hour_step = clock_time.hour + 5'd1;
    if (sec_step >= SECONDS_PER_MINUTE) begin
      tick_time.second = 6'd0;
      if (min_step >= MINUTES_PER_HOUR) begin
        tick_time.minute = 6'd0;
        if (hour_step >= HOURS_PER_DAY) begin
          tick_time.hour = 5'd0;
          tick_time.day  = clock_time.day + 8'd1;
        end else begin
          tick_time.hour = hour_step;
        end
      end else begin
        tick_time.minute = min_step;
      end
    end else begin
      tick_time.second = sec_step;
    end
  end

  always_comb begin
    idle_count_next  = idle_count;
    blinking_next    = blinking;
    beat_count_next  = beat_count;
    unlocked_next    = unlocked;
    clock_valid_next = clock_valid;
    closed_flag_next = closed_flag;
    clock_time_next  = clock_time;
    ended            = 1'b0;
    beat             = 1'b0;

    idle_step = (unlocked && !closed_flag && idle_count < COUNT_MAX) ?
                idle_count + 6'd1 : idle_count;
    beat_step = (beat_count < COUNT_MAX) ? beat_count + 6'd1 : beat_count;

    case (cmd)
      CMD_TICK: begin
        idle_count_next = idle_step;
        if (idle_step >= cfg.warn) begin
          blinking_next = 1'b1;
        end
        // timeout check runs even while locked
        if (idle_step >= cfg.timeout) begin
          idle_count_next = 6'd0;
          blinking_next   = 1'b0;
          ended           = 1'b1;
        end
        if (unlocked) begin
          beat_count_next = beat_step;
          if (beat_step >= cfg.period) begin
            beat            = 1'b1;
            beat_count_next = 6'd0;
          end
        end
        if (clock_valid) begin
          clock_time_next  = tick_time;
          closed_flag_next = !(tick_time.hour >= cfg.open && tick_time.hour < cfg.close);
        end
      end
      CMD_ACTIVITY: idle_count_next = 6'd0;
      CMD_SET_TIME: begin
        clock_time_next.day    = set_day;
        clock_time_next.hour   = set_hour;
        clock_time_next.minute = set_minute;
        clock_valid_next       = 1'b1;
      end
      CMD_UNLOCK: unlocked_next = 1'b1;
      CMD_LOCK:   unlocked_next = 1'b0;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idle_count  <= 6'd0;
      blinking    <= 1'b0;
      beat_count  <= 6'd0;
      unlocked    <= 1'b0;
      clock_valid <= 1'b0;
      closed_flag <= 1'b0;
      clock_time  <= '0;
    end else if (in_accept) begin
      idle_count  <= idle_count_next;
      blinking    <= blinking_next;
      beat_count  <= beat_count_next;
      unlocked    <= unlocked_next;
      clock_valid <= clock_valid_next;
      closed_flag <= closed_flag_next;
      clock_time  <= clock_time_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (in_accept) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (in_accept) begin
        blink_on        <= blinking_next;
        session_timeout <= ended;
        heartbeat       <= beat;
        out_of_hours    <= closed_flag_next;
        cur_day         <= clock_time_next.day;
        cur_hour        <= clock_time_next.hour;
        cur_minute      <= clock_time_next.minute;
        cur_second      <= clock_time_next.second;
      end
    end
  end

  // a session end always drops the blink
  a_timeout_clears_blink: assert property (@(posedge clk) disable iff (rst)
    out_valid && session_timeout |-> !blink_on)
    else $error("blink still on with session timeout");

  // the input side only stalls behind a held result
  a_stall_has_result: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with empty output register");

  // pulses come from ticks only
  a_pulse_from_tick: assert property (@(posedge clk) disable iff (rst)
    !rst && in_valid && !in_stall && cmd != CMD_TICK |=> !session_timeout && !heartbeat)
    else $error("pulse raised by a non-tick word");

endmodule

>>> tb/inactivity_timeout_and_clock_unit_tb.sv
// ----------------------------------------------------------------------------
// inactivity_timeout_and_clock_unit_tb
// Self-checking bench for the kiosk idle timeout and wall clock unit. Each
// command word is mirrored in a local model of the idle, heartbeat and clock
// counters, and every status word is compared field by field. Random idling
// is applied on both channels. The limits are reprogrammed between phases.
// ----------------------------------------------------------------------------
module inactivity_timeout_and_clock_unit_tb;
  import itc_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned DRAIN_CYCLES  = 4;
  localparam logic [2:0]  CMD_SPARE_LO  = 3'd5;
  localparam logic [2:0]  CMD_SPARE_MID = 3'd6;
  localparam logic [2:0]  CMD_SPARE_HI  = 3'd7;
  localparam logic [2:0]  REG_UNUSED    = 3'd5;

  typedef struct packed {
    logic      blink;
    logic      ended;
    logic      beat;
    logic      closed;
    itc_time_t now;
  } kiosk_status_t;

  logic        clk        = 1'b0;
  logic        rst        = 1'b1;
  logic        psel       = 1'b0;
  logic        penable    = 1'b0;
  logic        pwrite     = 1'b0;
  logic [4:0]  paddr      = '0;
  logic [31:0] pwdata     = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid   = 1'b0;
  logic        in_stall;
  logic [2:0]  cmd        = CMD_TICK;
  logic [7:0]  set_day    = '0;
  logic [4:0]  set_hour   = '0;
  logic [5:0]  set_minute = '0;
  logic        out_valid;
  logic        out_stall  = 1'b0;
  logic        blink_on;
  logic        session_timeout;
  logic        heartbeat;
  logic        out_of_hours;
  logic [7:0]  cur_day;
  logic [4:0]  cur_hour;
  logic [5:0]  cur_minute;
  logic [5:0]  cur_second;

  // local copy of the block state
  itc_cfg_t    cfg;
  itc_time_t   wall;
  logic [5:0]  idle_secs;
  logic [5:0]  beat_ticks;
  logic        blink_lvl;
  logic        is_unlocked;
  logic        time_known;
  logic        after_hours;

  kiosk_status_t status_q[$];
  kiosk_status_t want_st;
  int unsigned   err_count  = 0;
  int unsigned   cycles     = 0;
  int unsigned   stall_left = 0;
  bit            quiet      = 1'b0;

  inactivity_timeout_and_clock_unit dut (
    .clk             (clk),
    .rst             (rst),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .cmd             (cmd),
    .set_day         (set_day),
    .set_hour        (set_hour),
    .set_minute      (set_minute),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .blink_on        (blink_on),
    .session_timeout (session_timeout),
    .heartbeat       (heartbeat),
    .out_of_hours    (out_of_hours),
    .cur_day         (cur_day),
    .cur_hour        (cur_hour),
    .cur_minute      (cur_minute),
    .cur_second      (cur_second)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic void load_reset_state();
    cfg         = '{WARN_RESET, TIMEOUT_RESET, PERIOD_RESET, OPEN_RESET, CLOSE_RESET};
    wall        = '0;
    idle_secs   = '0;
    beat_ticks  = '0;
    blink_lvl   = 1'b0;
    is_unlocked = 1'b0;
    time_known  = 1'b0;
    after_hours = 1'b0;
  endfunction

  // Update the local state for one command word and return its status word.
  function automatic kiosk_status_t apply_command(logic [2:0] op, logic [7:0] d,
                                                  logic [4:0] h, logic [5:0] m);
    kiosk_status_t st;
    st = '0;
    case (op)
      CMD_TICK: begin
        if (is_unlocked && !after_hours && idle_secs < COUNT_MAX) idle_secs++;
        if (idle_secs >= cfg.warn) blink_lvl = 1'b1;
        // timeout is checked even while locked
        if (idle_secs >= cfg.timeout) begin
          idle_secs = '0;
          blink_lvl = 1'b0;
          st.ended  = 1'b1;
        end
        if (is_unlocked) begin
          if (beat_ticks < COUNT_MAX) beat_ticks++;
          if (beat_ticks >= cfg.period) begin
            st.beat    = 1'b1;
            beat_ticks = '0;
          end
        end
        if (time_known) begin
          wall.second = wall.second + 6'd1;
          if (wall.second >= SECONDS_PER_MINUTE) begin
            wall.second = '0;
            wall.minute = wall.minute + 6'd1;
            if (wall.minute >= MINUTES_PER_HOUR) begin
              wall.minute = '0;
              wall.hour   = wall.hour + 5'd1;
              if (wall.hour >= HOURS_PER_DAY) begin
                wall.hour = '0;
                wall.day  = wall.day + 8'd1;
              end
            end
          end
          after_hours = !(wall.hour >= cfg.open && wall.hour < cfg.close);
        end
      end
      CMD_ACTIVITY: idle_secs = '0;
      CMD_SET_TIME: begin
        // seconds are kept, the service-hours flag waits for the next tick
        wall.day    = d;
        wall.hour   = h;
        wall.minute = m;
        time_known  = 1'b1;
      end
      CMD_UNLOCK: is_unlocked = 1'b1;
      CMD_LOCK:   is_unlocked = 1'b0;
      default: ;
    endcase
    st.blink  = blink_lvl;
    st.closed = after_hours;
    st.now    = wall;
    return st;
  endfunction

  function automatic logic [31:0] reg_value(logic [2:0] idx);
    case (idx)
      REG_WARN:    return {26'd0, cfg.warn};
      REG_TIMEOUT: return {26'd0, cfg.timeout};
      REG_PERIOD:  return {26'd0, cfg.period};
      REG_OPEN:    return {27'd0, cfg.open};
      REG_CLOSE:   return {27'd0, cfg.close};
      default:     return '0;
    endcase
  endfunction

  function automatic void report(string what, logic [31:0] want, logic [31:0] got);
    err_count++;
    $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
  endfunction

  function automatic void check_field(string what, logic [31:0] want, logic [31:0] got);
    if (got !== want) report(what, want, got);
  endfunction

  // Status word checker
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (status_q.size() == 0) begin
        report("unexpected status word, cur_second", '0, 32'(cur_second));
      end else begin
        want_st = status_q.pop_front();
        check_field("blink_on", 32'(want_st.blink), 32'(blink_on));
        check_field("session_timeout", 32'(want_st.ended), 32'(session_timeout));
        check_field("heartbeat", 32'(want_st.beat), 32'(heartbeat));
        check_field("out_of_hours", 32'(want_st.closed), 32'(out_of_hours));
        check_field("cur_day", 32'(want_st.now.day), 32'(cur_day));
        check_field("cur_hour", 32'(want_st.now.hour), 32'(cur_hour));
        check_field("cur_minute", 32'(want_st.now.minute), 32'(cur_minute));
        check_field("cur_second", 32'(want_st.now.second), 32'(cur_second));
      end
    end
  end

  // Downstream stall bursts
  always @(negedge clk) begin
    if (stall_left != 0) begin
      out_stall = 1'b1;
      stall_left--;
    end else if (!quiet && $urandom_range(0, 9) == 0) begin
      out_stall  = 1'b1;
      stall_left = $urandom_range(0, 10);
    end else begin
      out_stall = 1'b0;
    end
  end

  task automatic send_word(input logic [2:0] op, input logic [7:0] d,
                           input logic [4:0] h, input logic [5:0] m);
    int unsigned gap;
    gap = (!quiet && $urandom_range(0, 7) == 0) ? $urandom_range(1, 11) : 0;
    if (gap != 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid   = 1'b1;
    cmd        = op;
    set_day    = d;
    set_hour   = h;
    set_minute = m;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    status_q.push_back(apply_command(op, d, h, m));
  endtask

  task automatic send_random(input logic [2:0] op);
    send_word(op, 8'($urandom), 5'($urandom), 6'($urandom));
  endtask

  // Hold the sender until every status word is back.
  task automatic wait_drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (status_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic apb_access(input logic wr, input logic [2:0] idx,
                            input logic [31:0] data, output logic [31:0] rdata);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = wr;
    paddr   = {idx, 2'b00};
    pwdata  = data;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    logic [31:0] rd;
    apb_access(1'b1, idx, val, rd);
    case (idx)
      REG_WARN:    cfg.warn    = val[5:0];
      REG_TIMEOUT: cfg.timeout = val[5:0];
      REG_PERIOD:  cfg.period  = val[5:0];
      REG_OPEN:    cfg.open    = val[4:0];
      REG_CLOSE:   cfg.close   = val[4:0];
      default: ;
    endcase
    if (idx <= REG_CLOSE) begin
      apb_access(1'b0, idx, '0, rd);
      if (rd !== reg_value(idx)) report($sformatf("register %0d", idx), reg_value(idx), rd);
    end
  endtask

  task automatic set_limits(input int unsigned warn, input int unsigned tmo,
                            input int unsigned period, input int unsigned open_h,
                            input int unsigned close_h);
    wait_drain();
    write_reg(REG_WARN, warn);
    write_reg(REG_TIMEOUT, tmo);
    write_reg(REG_PERIOD, period);
    write_reg(REG_OPEN, open_h);
    write_reg(REG_CLOSE, close_h);
  endtask

  task automatic run_random(input int unsigned n);
    int unsigned sent;
    int unsigned k;
    int unsigned pick;
    logic [2:0]  op;
    logic [4:0]  hr;
    logic [7:0]  dy;
    logic [5:0]  mn;
    sent = 0;
    while (sent < n) begin
      pick = $urandom_range(0, 9);
      if (pick <= 3) begin
        // unlocked session: mostly ticks, some activity, rare lock
        send_random(CMD_UNLOCK);
        k = $urandom_range(3, 70);
        repeat (k) begin
          pick = $urandom_range(0, 19);
          if (pick == 0) op = CMD_LOCK;
          else if (pick <= 2) op = CMD_ACTIVITY;
          else op = CMD_TICK;
          send_random(op);
        end
        sent += k + 1;
      end else if (pick <= 6) begin
        // set the clock close to a carry or a service-hours edge, then tick
        pick = $urandom_range(0, 3);
        if (pick == 0) hr = 5'd23;
        else if (pick == 1) hr = cfg.open - 5'd1;
        else if (pick == 2) hr = cfg.close - 5'd1;
        else hr = 5'($urandom_range(0, 23));
        dy = ($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom);
        mn = ($urandom_range(0, 1) == 0) ? 6'd59 : 6'($urandom_range(0, 59));
        send_word(CMD_SET_TIME, dy, hr, mn);
        k = $urandom_range(5, 70);
        repeat (k) send_random(CMD_TICK);
        sent += k + 1;
      end else begin
        k = $urandom_range(1, 10);
        repeat (k) send_random(3'($urandom_range(0, 7)));
        sent += k;
      end
      if ($urandom_range(0, 15) == 0) wait_drain();
    end
  endtask

  task automatic test_reset_state();
    send_word(CMD_SPARE_LO, '0, '0, '0);
    send_word(CMD_TICK, '0, '0, '0);
  endtask

  task automatic test_directed();
    set_limits(2, 3, 2, 8, 20);
    send_word(CMD_UNLOCK, '0, '0, '0);
    repeat (3) send_word(CMD_TICK, '0, '0, '0);
    send_word(CMD_ACTIVITY, '0, '0, '0);
    send_word(CMD_TICK, '0, '0, '0);
    send_word(CMD_LOCK, '0, '0, '0);
    send_word(CMD_TICK, '0, '0, '0);
    send_word(CMD_SET_TIME, 8'hFF, 5'd23, 6'd59);
    send_word(CMD_TICK, '0, '0, '0);
    send_word(CMD_SET_TIME, 8'h00, 5'd0, 6'd0);
    send_word(CMD_TICK, '0, '0, '0);
    // out-of-range hour and minute are stored as given
    send_word(CMD_SET_TIME, 8'hAA, 5'd31, 6'd63);
    send_word(CMD_TICK, '0, '0, '0);
    send_word(CMD_SET_TIME, 8'h55, 5'd16, 6'd42);
    send_word(CMD_UNLOCK, '0, '0, '0);
    send_word(CMD_TICK, '0, '0, '0);
    send_word(CMD_SPARE_LO, '0, '0, '0);
    send_word(CMD_SPARE_MID, 8'hFF, 5'h1F, 6'h3F);
    send_word(CMD_SPARE_HI, 8'hFF, 5'h1F, 6'h3F);
    send_word(CMD_ACTIVITY, 8'hFF, 5'h1F, 6'h3F);
    send_word(CMD_TICK, 8'hFF, 5'h1F, 6'h3F);
  endtask

  task automatic test_typical_limits();
    set_limits(4, 9, 5, 6, 18);
    run_random(140);
  endtask

  task automatic test_low_extremes();
    set_limits(0, 1, 1, 0, 24);
    run_random(100);
  endtask

  // a write outside the register map must leave every limit untouched
  task automatic test_unused_register();
    wait_drain();
    write_reg(REG_UNUSED, 32'hFFFF_FFFF);
    run_random(30);
  endtask

  task automatic test_zero_thresholds();
    set_limits(0, 0, 0, 0, 0);
    run_random(80);
  endtask

  task automatic test_high_extremes();
    set_limits(63, 63, 63, 23, 24);
    run_random(120);
  endtask

  task automatic test_reversed_window();
    set_limits(10, 20, 7, 20, 8);
    quiet = 1'b1;
    run_random(100);
  endtask

  initial begin
    load_reset_state();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_reset_state();
    test_directed();
    test_typical_limits();
    test_low_extremes();
    test_unused_register();
    test_zero_thresholds();
    test_high_extremes();
    test_reversed_window();
    wait_drain();
    if (err_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
